/* src/fan_button_power_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// Fan button power sequencer: assertion macros
// Shared property wrappers for the checker on the top level's ports.
// ----------------------------------------------------------------------------
`ifndef FAN_BUTTON_POWER_SEQUENCER_DEFINES_SVH
`define FAN_BUTTON_POWER_SEQUENCER_DEFINES_SVH

// Property checked out of reset.
`define FBPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every edge, reset included.
`define FBPS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/fbps_pkg.sv */
// ----------------------------------------------------------------------------
// Fan button power sequencer package
// Widths, reset values, register indexes and shared structs.
// ----------------------------------------------------------------------------
package fbps_pkg;

  localparam int unsigned TickW = 8;
  localparam int unsigned HzW   = 10;
  localparam int unsigned IdxW  = 3;

  localparam logic [TickW-1:0] GuardRst = 8'd70;
  localparam logic [TickW-1:0] BeepRst  = 8'd50;
  localparam logic [HzW-1:0]   StepRst  = 10'd100;
  localparam logic [HzW-1:0]   TopRst   = 10'd300;
  localparam logic [HzW-1:0]   StartRst = 10'd100;
  localparam logic [HzW-1:0]   HzMax    = 10'd1023;

  typedef enum logic [IdxW-1:0] {
    REG_GUARD_TICKS = 3'd0,
    REG_BEEP_TICKS  = 3'd1,
    REG_SPEED_STEP  = 3'd2,
    REG_SPEED_TOP   = 3'd3,
    REG_START_HZ    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] guard_ticks;
    logic [TickW-1:0] beep_ticks;
    logic [HzW-1:0]   speed_step;
    logic [HzW-1:0]   speed_top;
    logic [HzW-1:0]   start_hz;
  } cfg_t;

  typedef struct packed {
    logic           power_on;
    logic           swing_on;
    logic           led_high;
    logic           led_mid;
    logic           led_low;
    logic           buzzer_on;
    logic [HzW-1:0] req_hz;
  } res_t;

endpackage

/* src/fan_button_power_sequencer.sv */
// ----------------------------------------------------------------------------
// Fan button power sequencer
// Button handling, beep and power-down sequencing for a fan controller.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): one beat per millisecond tick with
//   the three active-low button levels and the present generator frequency.
//   Output channel (out_valid_o/out_ready_i): one beat per input beat with
//   the state after that tick: power, swing, speed LEDs, buzzer and target.
//   Config channel (cfg_valid_i/cfg_ready_o): writes one setting by index,
//   always ready; indexes above the last register are dropped.
// Flow: a beat is taken into the input register, then moves through the tick
//   logic into the output register once that register has room. Throughput
//   is one beat per cycle while out_ready_i does not stall, set by the single
//   pass from input register through the tick logic to the output register.
// Stall: while the output beat waits, the input register still fills; with
//   both registers full in_ready_o drops until out_ready_i is seen.
// Reset: settings return to defaults, keys read as released, fan off,
//   timers cleared, both channels empty.
// ----------------------------------------------------------------------------
module fan_button_power_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fbps_pkg::IdxW-1:0]    cfg_index_i,
  input  logic [fbps_pkg::HzW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         key_speed_i,
  input  logic                         key_swing_i,
  input  logic                         key_off_i,
  input  logic [fbps_pkg::HzW-1:0]     present_hz_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         power_on_o,
  output logic                         swing_on_o,
  output logic                         led_low_o,
  output logic                         led_mid_o,
  output logic                         led_high_o,
  output logic                         buzzer_on_o,
  output logic [fbps_pkg::HzW-1:0]     req_hz_o
);
  import fbps_pkg::*;

  cfg_t           cfg;
  res_t           res, res_q;
  logic           in_valid_q, in_valid_d;
  logic           out_valid_q, out_valid_d;
  logic           key_speed_q, key_swing_q, key_off_q;
  logic [HzW-1:0] present_q;
  logic           adv, in_take;

  assign cfg_ready_o = 1'b1;

  fbps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // advance when the held tick has room in the output register
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign in_take    = in_valid_i && in_ready_o;

  assign in_valid_d  = in_take ? 1'b1 : (adv ? 1'b0 : in_valid_q);
  assign out_valid_d = adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      key_speed_q <= key_speed_i;
      key_swing_q <= key_swing_i;
      key_off_q   <= key_off_i;
      present_q   <= present_hz_i;
    end
    if (adv) res_q <= res;
  end

  fbps_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (adv),
    .cfg_i        (cfg),
    .key_speed_i  (key_speed_q),
    .key_swing_i  (key_swing_q),
    .key_off_i    (key_off_q),
    .present_hz_i (present_q),
    .res_o        (res)
  );

  assign out_valid_o = out_valid_q;
  assign power_on_o  = res_q.power_on;
  assign swing_on_o  = res_q.swing_on;
  assign led_low_o   = res_q.led_low;
  assign led_mid_o   = res_q.led_mid;
  assign led_high_o  = res_q.led_high;
  assign buzzer_on_o = res_q.buzzer_on;
  assign req_hz_o    = res_q.req_hz;

endmodule

/* src/fbps_cfg.sv */
// ----------------------------------------------------------------------------
// Fan button power sequencer: configuration registers
// Holds the five settings, written one at a time by index.
// ----------------------------------------------------------------------------
module fbps_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [fbps_pkg::IdxW-1:0]    cfg_index_i,
  input  logic [fbps_pkg::HzW-1:0]     cfg_data_i,
  output fbps_pkg::cfg_t               cfg_o
);
  import fbps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GUARD_TICKS: cfg_d.guard_ticks = cfg_data_i[TickW-1:0];
        REG_BEEP_TICKS:  cfg_d.beep_ticks  = cfg_data_i[TickW-1:0];
        REG_SPEED_STEP:  cfg_d.speed_step  = cfg_data_i;
        REG_SPEED_TOP:   cfg_d.speed_top   = cfg_data_i;
        REG_START_HZ:    cfg_d.start_hz    = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.guard_ticks <= GuardRst;
      cfg_q.beep_ticks  <= BeepRst;
      cfg_q.speed_step  <= StepRst;
      cfg_q.speed_top   <= TopRst;
      cfg_q.start_hz    <= StartRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/fbps_core.sv */
// ----------------------------------------------------------------------------
// Fan button power sequencer: tick logic
// Edge detect, guard and beep timers, power and speed state, one tick a step.
// ----------------------------------------------------------------------------
module fbps_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  fbps_pkg::cfg_t            cfg_i,
  input  logic                      key_speed_i,
  input  logic                      key_swing_i,
  input  logic                      key_off_i,
  input  logic [fbps_pkg::HzW-1:0]  present_hz_i,
  output fbps_pkg::res_t            res_o
);
  import fbps_pkg::*;

  logic [2:0]       last_keys_q, last_keys_d;
  logic [TickW-1:0] guard_q, guard_d;
  logic [TickW-1:0] beep_q, beep_d;
  logic             powered_q, powered_d;
  logic             stop_q, stop_d;
  logic             swing_q, swing_d;
  logic [2:0]       leds_q, leds_d;
  logic [HzW-1:0]   tgt_q, tgt_d;

  logic [2:0]       keys, falls;
  logic             pressed;
  logic [HzW:0]     sum, band2;
  logic [HzW-1:0]   stepped, tgt_spd;
  logic [2:0]       leds_spd;

  assign keys  = {key_off_i, key_swing_i, key_speed_i};
  assign falls = last_keys_q & ~keys;

  // saturate the stepped target, wrap once the top is reached
  assign sum     = {1'b0, tgt_q} + {1'b0, cfg_i.speed_step};
  assign stepped = sum[HzW] ? HzMax : sum[HzW-1:0];
  assign tgt_spd = (!powered_q || tgt_q >= cfg_i.speed_top) ? cfg_i.start_hz : stepped;

  assign band2       = {cfg_i.speed_step, 1'b0};
  assign leds_spd[0] = (tgt_spd != '0) && (tgt_spd <= cfg_i.speed_step);
  assign leds_spd[1] = (tgt_spd > cfg_i.speed_step) && ({1'b0, tgt_spd} <= band2);
  assign leds_spd[2] = {1'b0, tgt_spd} > band2;

  always_comb begin
    last_keys_d = last_keys_q;
    guard_d     = guard_q;
    beep_d      = beep_q;
    powered_d   = powered_q;
    stop_d      = stop_q;
    swing_d     = swing_q;
    leds_d      = leds_q;
    tgt_d       = tgt_q;
    pressed     = 1'b0;

    if (guard_q != '0) begin
      guard_d = guard_q - 1'b1;
    end else begin
      if (falls[0]) begin
        pressed   = 1'b1;
        powered_d = 1'b1;
        stop_d    = 1'b0;
        tgt_d     = tgt_spd;
        leds_d    = leds_spd;
      end
      if (falls[1]) begin
        pressed = 1'b1;
        if (powered_d) swing_d = !swing_d;
      end
      if (falls[2]) begin
        pressed = 1'b1;
        if (powered_d && !stop_d) begin
          swing_d = 1'b0;
          stop_d  = 1'b1;
          tgt_d   = '0;
        end
      end
      last_keys_d = keys;
      if (pressed) begin
        guard_d = cfg_i.guard_ticks;
        beep_d  = cfg_i.beep_ticks;
      end
    end

    if (!pressed && beep_q != '0) beep_d = beep_q - 1'b1;

    // cut power once the fan has spun down
    if (stop_d && present_hz_i == '0 && tgt_d == '0) begin
      powered_d = 1'b0;
      stop_d    = 1'b0;
      leds_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_keys_q <= '1;
      guard_q     <= '0;
      beep_q      <= '0;
      powered_q   <= 1'b0;
      stop_q      <= 1'b0;
      swing_q     <= 1'b0;
      leds_q      <= '0;
      tgt_q       <= '0;
    end else if (step_i) begin
      last_keys_q <= last_keys_d;
      guard_q     <= guard_d;
      beep_q      <= beep_d;
      powered_q   <= powered_d;
      stop_q      <= stop_d;
      swing_q     <= swing_d;
      leds_q      <= leds_d;
      tgt_q       <= tgt_d;
    end
  end

  assign res_o.power_on  = powered_d;
  assign res_o.swing_on  = swing_d;
  assign res_o.led_high  = leds_d[2];
  assign res_o.led_mid   = leds_d[1];
  assign res_o.led_low   = leds_d[0];
  assign res_o.buzzer_on = beep_d != '0;
  assign res_o.req_hz    = tgt_d;

endmodule

/* src/fbps_checker.sv */
// ----------------------------------------------------------------------------
// Fan button power sequencer: port checker
// Watches the top level's ports and flags broken output behavior.
// ----------------------------------------------------------------------------
`include "fan_button_power_sequencer_defines.svh"

module fbps_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      power_on_o,
  input logic                      swing_on_o,
  input logic                      led_low_o,
  input logic                      led_mid_o,
  input logic                      led_high_o,
  input logic                      buzzer_on_o,
  input logic [fbps_pkg::HzW-1:0]  req_hz_o
);
  import fbps_pkg::*;

  logic [2:0]     leds;
  logic [HzW+5:0] beat;
  logic           stall;
  logic           off_beat;

  assign leds     = {led_high_o, led_mid_o, led_low_o};
  assign beat     = {power_on_o, swing_on_o, leds, buzzer_on_o, req_hz_o};
  assign stall    = out_valid_o && !out_ready_i;
  assign off_beat = out_valid_o && !power_on_o;

  // hold a stalled result beat
  `FBPS_ASSERT(a_out_hold, stall |=> out_valid_o && $stable(beat), "stalled result beat changed")

  `FBPS_ASSERT(a_led_onehot, out_valid_o |-> $onehot0(leds), "more than one speed LED lit")

  // a fan that is off asks for nothing and shows no speed
  `FBPS_ASSERT(a_off_idle, off_beat |-> req_hz_o == '0 && leds == '0, "target or LEDs set while off")

  `FBPS_ASSERT_RST(a_rst_empty, !rst_ni |-> !out_valid_o, "result beat shown during reset")

endmodule

bind fan_button_power_sequencer fbps_checker u_fbps_checker (.*);
